/* hw/rtl/mfae_pkg.sv */
// Shared types, codes and arithmetic helpers for the MLP forward and error unit.
// No dependencies; mfae_cell, mfae_mac and the top level import this package.
package mfae_pkg;

   localparam int MAX_LAYERS_DEF   = 4;
   localparam int MAX_WIDTH_DEF    = 16;
   localparam int WEIGHT_DEPTH_DEF = 1024;
   localparam int FRAC_BITS_DEF    = 16;

   localparam int VALUE_W    = 32;
   localparam int ACC_W      = 64;
   localparam int ERR_W      = 48;
   localparam int CNT_REG_W  = 5;
   localparam int LAYER_REG_W = 3;
   localparam int WIDX_W     = 10;
   localparam int EIDX_W     = 4;
   localparam int OIDX_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 88;

   localparam logic [ERR_W-1:0] ERR_MAX = '1;

   typedef enum logic [1:0] {
      OP_WRITE_WEIGHT = 2'd0,
      OP_INPUT        = 2'd1,
      OP_TARGET       = 2'd2,
      OP_CLEAR        = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INPUT_COUNT = 3'd0,
      CSR_LAYER_COUNT = 3'd1,
      CSR_LAYER0      = 3'd2,
      CSR_LAYER1      = 3'd3,
      CSR_LAYER2      = 3'd4,
      CSR_LAYER3      = 3'd5
   } csr_index_type;

   typedef enum logic [0:0] {
      KIND_OUTPUT = 1'b0,
      KIND_ERROR  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Control of the operand chain.
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   // Position of one multiply within its neuron.
   typedef struct packed {
      logic first;
      logic last;
   } mac_tag_type;

   // Signed 64-bit add that sticks at the bounds on overflow.
   function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W-1:0] s;
      s = a + b;
      if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
         s = b[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return s;
   endfunction

endpackage

/* hw/rtl/mfae_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mfae_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/mfae_cell.sv */
// One cell of the operand ring: holds one layer input and passes it to its neighbor.
// Depends on mfae_pkg.
module mfae_cell (
   input  logic                          clock,
   input  mfae_pkg::cell_ctl_type        ctl,
   input  logic [mfae_pkg::VALUE_W-1:0]  load_value,
   input  logic [mfae_pkg::VALUE_W-1:0]  neighbor_value,
   input  logic [mfae_pkg::VALUE_W-1:0]  head_value,
   input  logic                          wrap,
   output logic [mfae_pkg::VALUE_W-1:0]  value
);
   import mfae_pkg::*;

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   // The cell at the end of the active ring takes the head value back.
   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = load_value;
      end else if (ctl.shift) begin
         value_in = wrap ? head_value : neighbor_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule

/* hw/rtl/mfae_mac.sv */
// Pipelined multiply-accumulate with saturation and Q16.16 rescaling.
// Depends on mfae_pkg.
module mfae_mac #(
   parameter int IDX_W     = 4,
   parameter int FRAC_BITS = mfae_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                issue,
   input  mfae_pkg::mac_tag_type               issue_tag,
   input  logic [IDX_W-1:0]                    issue_neuron,
   input  logic signed [mfae_pkg::VALUE_W-1:0] issue_x,
   input  logic signed [mfae_pkg::VALUE_W-1:0] weight,
   output logic                                busy,
   output logic                                out_we,
   output logic [IDX_W-1:0]                    out_idx,
   output logic signed [mfae_pkg::VALUE_W-1:0] out_value
);
   import mfae_pkg::*;

   logic                      v1_ff, v2_ff, v3_ff;
   mac_tag_type               tag1_ff, tag2_ff, tag3_ff;
   logic [IDX_W-1:0]          n1_ff, n2_ff, n3_ff;
   logic signed [VALUE_W-1:0] x1_ff;
   logic signed [ACC_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   shifted;

   always_comb begin
      acc_in = tag2_ff.first ? prod_ff : sat_add(acc_ff, prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      tag1_ff <= issue_tag;
      n1_ff   <= issue_neuron;
      x1_ff   <= issue_x;
      tag2_ff <= tag1_ff;
      n2_ff   <= n1_ff;
      prod_ff <= ACC_W'(x1_ff) * ACC_W'(weight);
      tag3_ff <= tag2_ff;
      n3_ff   <= n2_ff;
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Arithmetic shift rounds toward minus infinity, then clip to 32 bits.
   always_comb begin
      shifted = acc_ff >>> FRAC_BITS;
      if (shifted > ACC_W'(32'sh7fff_ffff)) begin
         out_value = 32'sh7fff_ffff;
      end else if (shifted < -ACC_W'(64'sh8000_0000)) begin
         out_value = 32'sh8000_0000;
      end else begin
         out_value = shifted[VALUE_W-1:0];
      end
   end

   assign out_we  = v3_ff & tag3_ff.last;
   assign out_idx = n3_ff;
   assign busy    = v1_ff | v2_ff | v3_ff;
endmodule

/* hw/rtl/mlp_forward_abs_error_unit.sv */
// Top level of the MLP forward and absolute-error unit.
// Depends on mfae_pkg, mfae_ram, mfae_cell and mfae_mac.
//
// The unit evaluates a bias-free fully connected network in signed Q16.16. Write-weight,
// clear and non-final input or target items are taken in the idle state. An input item marked
// last starts a forward pass: for every layer the ring of MAX_WIDTH cells is loaded, then one
// multiply-accumulate is issued per cycle (one weight store read per cycle sets this), and the
// multiply pipeline drains before the next layer is loaded or the outputs are emitted. A target
// item marked last reports the error sum in the cycle after it is accepted. While a pass runs
// or outputs are emitted, req_tready is low.
// Weight store entries must be written before any pass reads them.
module mlp_forward_abs_error_unit #(
   parameter int MAX_LAYERS   = mfae_pkg::MAX_LAYERS_DEF,
   parameter int MAX_WIDTH    = mfae_pkg::MAX_WIDTH_DEF,
   parameter int WEIGHT_DEPTH = mfae_pkg::WEIGHT_DEPTH_DEF,
   parameter int FRAC_BITS    = mfae_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: weight_index[9:0], element_index[13:10], value[45:14], zero fill [47:46]
   input  logic [mfae_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: operation[1:0]
   input  logic [1:0]                        req_tuser,
   input  logic                              req_tlast,
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: out_index[3:0], out_value[35:4], error_total[83:36], error_saturated[84],
   // zero fill [87:85]
   output logic [mfae_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: kind[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   // Configuration port.
   input  logic                              csr_we,
   input  logic [mfae_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mfae_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mfae_pkg::*;

   localparam int NW   = $clog2(MAX_WIDTH + 1);
   localparam int IW   = $clog2(MAX_WIDTH);
   localparam int AW   = $clog2(WEIGHT_DEPTH);
   localparam int LMAX = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;

   // Configuration registers.
   logic [CNT_REG_W-1:0]   input_count_ff;
   logic [LAYER_REG_W-1:0] layer_count_ff;
   logic [CNT_REG_W-1:0]   neurons_ff [4];

   // Request fields.
   op_type                    req_op;
   logic [WIDX_W-1:0]         req_widx;
   logic [EIDX_W-1:0]         req_eidx;
   logic signed [VALUE_W-1:0] req_value;
   logic                      req_take;
   logic                      rsp_free;

   assign req_op    = op_type'(req_tuser);
   assign req_widx  = req_tdata[9:0];
   assign req_eidx  = req_tdata[13:10];
   assign req_value = req_tdata[45:14];

   // Datapath state.
   state_type                 state_ff, state_in;
   logic [VALUE_W-1:0]        in_buf_ff  [MAX_WIDTH];
   logic signed [VALUE_W-1:0] out_buf_ff [MAX_WIDTH];
   logic [1:0]                layer_ff, layer_in;
   logic [IW-1:0]             w_ff, w_in;
   logic [IW-1:0]             n_ff, n_in;
   logic [IW-1:0]             e_ff, e_in;
   logic [NW-1:0]             nin_ff, nin_in;
   logic [NW-1:0]             nn_ff, nn_in;
   logic [AW-1:0]             wpos_ff, wpos_in;
   logic [ERR_W-1:0]          err_ff, err_in;
   logic                      err_sat_ff, err_sat_in;

   // Result register.
   logic                      rsp_valid_ff;
   kind_type                  rsp_kind_ff;
   logic [OIDX_W-1:0]         rsp_idx_ff;
   logic [VALUE_W-1:0]        rsp_value_ff;
   logic [ERR_W-1:0]          rsp_err_ff;
   logic                      rsp_sat_ff;
   logic                      rsp_last_ff;

   // Clamped counts.
   logic [NW-1:0] cnt_inputs;
   logic [NW-1:0] cnt_layer_n [4];
   logic [2:0]    layers_used;
   logic [NW-1:0] cnt_final;

   function automatic logic [NW-1:0] clamp_w(input logic [CNT_REG_W-1:0] v);
      logic [NW-1:0] r;
      if (v == '0) begin
         r = NW'(1);
      end else if (32'(v) > MAX_WIDTH) begin
         r = NW'(MAX_WIDTH);
      end else begin
         r = NW'(v);
      end
      return r;
   endfunction

   always_comb begin
      cnt_inputs = clamp_w(input_count_ff);
      for (int i = 0; i < 4; i++) begin
         cnt_layer_n[i] = clamp_w(neurons_ff[i]);
      end
      if (layer_count_ff == '0) begin
         layers_used = 3'd1;
      end else if (32'(layer_count_ff) > LMAX) begin
         layers_used = 3'(LMAX);
      end else begin
         layers_used = layer_count_ff;
      end
      cnt_final = cnt_layer_n[2'(layers_used - 3'd1)];
   end

   // Shared read of the output buffer: emitted value or target comparison.
   logic [IW-1:0]             ob_idx;
   logic signed [VALUE_W-1:0] ob_value;
   assign ob_idx   = (state_ff == ST_EMIT) ? e_ff : IW'(req_eidx);
   assign ob_value = out_buf_ff[ob_idx];

   // Operand ring.
   cell_ctl_type       ring_ctl;
   logic [VALUE_W-1:0] ring_value [MAX_WIDTH];
   logic [VALUE_W-1:0] ring_load  [MAX_WIDTH];

   for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_ring
      assign ring_load[i] = (layer_ff == 2'd0) ? in_buf_ff[i] : out_buf_ff[i];
      mfae_cell u_cell (
         .clock          (clock),
         .ctl            (ring_ctl),
         .load_value     (ring_load[i]),
         .neighbor_value (ring_value[(i + 1) % MAX_WIDTH]),
         .head_value     (ring_value[0]),
         .wrap           (32'(nin_ff) == i + 1),
         .value          (ring_value[i])
      );
   end

   // Weight store and multiply-accumulate pipeline.
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [VALUE_W-1:0] ram_rdata;
   logic               issue;
   mac_tag_type        issue_tag;
   logic               mac_busy;
   logic               mac_we;
   logic [IW-1:0]      mac_idx;
   logic signed [VALUE_W-1:0] mac_value;

   if (WEIGHT_DEPTH >= 1024) begin : g_waddr_wide
      assign ram_waddr = AW'(req_widx);
   end else begin : g_waddr_mod
      assign ram_waddr = AW'(req_widx % WEIGHT_DEPTH);
   end

   mfae_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (WEIGHT_DEPTH)
   ) u_weights (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_value),
      .rd_addr (wpos_ff),
      .rd_data (ram_rdata)
   );

   mfae_mac #(
      .IDX_W     (IW),
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock        (clock),
      .reset        (reset),
      .issue        (issue),
      .issue_tag    (issue_tag),
      .issue_neuron (n_ff),
      .issue_x      (ring_value[0]),
      .weight       (ram_rdata),
      .busy         (mac_busy),
      .out_we       (mac_we),
      .out_idx      (mac_idx),
      .out_value    (mac_value)
   );

   // Handshake.
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) & rsp_free;
   assign req_take   = req_tvalid & req_tready;

   logic w_end, n_end;
   assign w_end = ({1'b0, w_ff} == (IW + 1)'(nin_ff - NW'(1)));
   assign n_end = ({1'b0, n_ff} == (IW + 1)'(nn_ff - NW'(1)));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_op == OP_INPUT && req_tlast) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_RUN;
         ST_RUN: begin
            if (w_end && n_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = ({1'b0, layer_ff} == layers_used - 3'd1) ? ST_EMIT : ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (rsp_free && {1'b0, e_ff} == (IW + 1)'(nn_ff - NW'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Target error arithmetic.
   logic signed [VALUE_W:0] diff;
   logic [VALUE_W:0]        abs_diff;
   logic [ERR_W:0]          err_sum;
   always_comb begin
      diff     = (VALUE_W + 1)'(ob_value) - (VALUE_W + 1)'(req_value);
      abs_diff = diff[VALUE_W] ? (VALUE_W + 1)'(-diff) : (VALUE_W + 1)'(diff);
      err_sum  = {1'b0, err_ff} + (ERR_W + 1)'(abs_diff);
   end

   // Datapath control.
   always_comb begin
      layer_in   = layer_ff;
      w_in       = w_ff;
      n_in       = n_ff;
      e_in       = e_ff;
      nin_in     = nin_ff;
      nn_in      = nn_ff;
      wpos_in    = wpos_ff;
      err_in     = err_ff;
      err_sat_in = err_sat_ff;
      ring_ctl   = '0;
      ram_we     = 1'b0;
      issue      = 1'b0;
      issue_tag  = '{first: (w_ff == '0), last: w_end};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_op)
                  OP_WRITE_WEIGHT: ram_we = 1'b1;
                  OP_INPUT: begin
                     layer_in = 2'd0;
                     wpos_in  = '0;
                  end
                  OP_TARGET: begin
                     if ({1'b0, req_eidx} < (EIDX_W + 1)'(cnt_final)) begin
                        if (err_sum >= (ERR_W + 1)'(ERR_MAX)) begin
                           err_in     = ERR_MAX;
                           err_sat_in = 1'b1;
                        end else begin
                           err_in = err_sum[ERR_W-1:0];
                        end
                     end
                  end
                  OP_CLEAR: begin
                     err_in     = '0;
                     err_sat_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: begin
            ring_ctl.load = 1'b1;
            nin_in = (layer_ff == 2'd0) ? cnt_inputs : cnt_layer_n[layer_ff - 2'd1];
            nn_in  = cnt_layer_n[layer_ff];
            w_in   = '0;
            n_in   = '0;
         end
         ST_RUN: begin
            issue          = 1'b1;
            ring_ctl.shift = 1'b1;
            wpos_in = (32'(wpos_ff) == WEIGHT_DEPTH - 1) ? '0 : wpos_ff + AW'(1);
            if (w_end) begin
               w_in = '0;
               n_in = n_ff + IW'(1);
            end else begin
               w_in = w_ff + IW'(1);
            end
         end
         ST_DRAIN: begin
            e_in = '0;
            if (!mac_busy && {1'b0, layer_ff} != layers_used - 3'd1) begin
               layer_in = layer_ff + 2'd1;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               e_in = e_ff + IW'(1);
            end
         end
         default: ;
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         input_count_ff <= CNT_REG_W'(1);
         layer_count_ff <= LAYER_REG_W'(1);
         for (int i = 0; i < 4; i++) begin
            neurons_ff[i] <= CNT_REG_W'(1);
         end
         for (int i = 0; i < MAX_WIDTH; i++) begin
            in_buf_ff[i]  <= '0;
            out_buf_ff[i] <= '0;
         end
         err_ff       <= '0;
         err_sat_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         err_ff     <= err_in;
         err_sat_ff <= err_sat_in;

         if (csr_we) begin
            unique case (csr_index)
               CSR_INPUT_COUNT: input_count_ff <= csr_wdata;
               CSR_LAYER_COUNT: layer_count_ff <= csr_wdata[LAYER_REG_W-1:0];
               CSR_LAYER0:      neurons_ff[0]  <= csr_wdata;
               CSR_LAYER1:      neurons_ff[1]  <= csr_wdata;
               CSR_LAYER2:      neurons_ff[2]  <= csr_wdata;
               CSR_LAYER3:      neurons_ff[3]  <= csr_wdata;
               default: ;
            endcase
         end

         if (req_take && req_op == OP_INPUT && 32'(req_eidx) < MAX_WIDTH) begin
            in_buf_ff[IW'(req_eidx)] <= req_value;
         end
         if (mac_we) begin
            out_buf_ff[mac_idx] <= mac_value;
         end

         // Result register: an error report or one network output.
         if (req_take && req_op == OP_TARGET && req_tlast) begin
            rsp_valid_ff <= 1'b1;
         end else if (state_ff == ST_EMIT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      layer_ff <= layer_in;
      w_ff     <= w_in;
      n_ff     <= n_in;
      e_ff     <= e_in;
      nin_ff   <= nin_in;
      nn_ff    <= nn_in;
      wpos_ff  <= wpos_in;

      if (req_take && req_op == OP_TARGET && req_tlast) begin
         rsp_kind_ff  <= KIND_ERROR;
         rsp_idx_ff   <= '0;
         rsp_value_ff <= '0;
         rsp_err_ff   <= err_in;
         rsp_sat_ff   <= err_sat_in;
         rsp_last_ff  <= 1'b1;
      end else if (state_ff == ST_EMIT && rsp_free) begin
         rsp_kind_ff  <= KIND_OUTPUT;
         rsp_idx_ff   <= OIDX_W'(e_ff);
         rsp_value_ff <= ob_value;
         rsp_err_ff   <= '0;
         rsp_sat_ff   <= 1'b0;
         rsp_last_ff  <= ({1'b0, e_ff} == (IW + 1)'(nn_ff - NW'(1)));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_sat_ff, rsp_err_ff, rsp_value_ff, rsp_idx_ff};
endmodule
